// File: src/lprpt_pkg.sv
// ---------------------------------------------------------------------------
// lprpt_pkg
// shared constants, arctangent table and types for the lidar ring/pose block
// ---------------------------------------------------------------------------
package lprpt_pkg;

    localparam int RingCount    = 16;
    localparam int CordicStages = 16;
    localparam int MinXyMm      = 200;
    localparam int SqrtSteps    = 4;   // root bits resolved per pipeline stage

    localparam logic signed [31:0] CordicGainQ30 = 32'sd652032874;

    // register indexes on the configuration port
    localparam logic [2:0] RegPoseX    = 3'd0;
    localparam logic [2:0] RegPoseY    = 3'd1;
    localparam logic [2:0] RegPoseZ    = 3'd2;
    localparam logic [2:0] RegHeading  = 3'd3;
    localparam logic [2:0] RegSensorHt = 3'd4;

    function automatic logic [31:0] atan_entry(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic signed [23:0] pose_x;
        logic signed [23:0] pose_y;
        logic signed [23:0] pose_z;
        logic        [15:0] heading;
        logic signed [15:0] sensor_height;
    } t_cfg;

endpackage

// File: src/lidar_point_ring_and_pose_transform.sv
// ---------------------------------------------------------------------------
// lidar_point_ring_and_pose_transform
// ring index, azimuth, heading rotation and world point of one lidar point
// ---------------------------------------------------------------------------
// channel  | ports                                   | handshake
// point    | i_point_x/y/z, i_intensity_in, finite   | start & !busy
// result   | o_ring_id .. o_intensity_out            | o_valid, one cycle
// config   | i_cfg_we, i_cfg_index, i_cfg_data       | i_cfg_we
//
// one point accepted every cycle; busy is never raised. o_valid rises
// after these registers in order: input, squares, 8 square-root stages
// of 4 root bits, the elevation cordic with its input register, then
// product and output registers. heading sin/cos comes from its own
// cordic pipeline and settles after a heading write has passed the
// config, cordic input, cordic stage and sin/cos registers. reset clears
// the valid bits and the configuration registers; the receiver cannot stall.
// ---------------------------------------------------------------------------
module lidar_point_ring_and_pose_transform (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [18:0] i_point_x,
    input  logic signed [18:0] i_point_y,
    input  logic signed [18:0] i_point_z,
    input  logic        [7:0]  i_intensity_in,
    input  logic               i_point_finite,
    input  logic               i_cfg_we,
    input  logic        [2:0]  i_cfg_index,
    input  logic        [23:0] i_cfg_data,
    output logic               o_valid,
    output logic        [3:0]  o_ring_id,
    output logic        [15:0] o_azimuth,
    output logic signed [19:0] o_rotated_x,
    output logic signed [19:0] o_rotated_y,
    output logic signed [18:0] o_rotated_z,
    output logic signed [23:0] o_world_x,
    output logic signed [23:0] o_world_y,
    output logic signed [23:0] o_world_z,
    output logic        [7:0]  o_intensity_out
);

    localparam int N   = lprpt_pkg::CordicStages;
    localparam int SQS = 32 / lprpt_pkg::SqrtSteps;  // 8 sqrt stages, 4 bits each
    localparam int LAT = 1 + SQS + 1 + N + 1;        // side delay depth plus one

    lprpt_pkg::t_cfg r_cfg;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lprpt_pkg::RegPoseX:    r_cfg.pose_x        <= i_cfg_data;
                lprpt_pkg::RegPoseY:    r_cfg.pose_y        <= i_cfg_data;
                lprpt_pkg::RegPoseZ:    r_cfg.pose_z        <= i_cfg_data;
                lprpt_pkg::RegHeading:  r_cfg.heading       <= i_cfg_data[15:0];
                lprpt_pkg::RegSensorHt: r_cfg.sensor_height <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ---------------- heading sin/cos pipeline (free running) --------------
    logic signed [33:0] r_hx [0:N];
    logic signed [33:0] r_hy [0:N];
    logic signed [33:0] r_ha [0:N];
    logic               r_hn [0:N];
    logic signed [33:0] w_a0;

    assign w_a0 = 34'(signed'({r_cfg.heading, 16'h0}));

    always_ff @(posedge i_clk) begin
        r_hx[0] <= 34'(lprpt_pkg::CordicGainQ30);
        r_hy[0] <= '0;
        if (w_a0 > 34'sh40000000) begin
            r_ha[0] <= w_a0 - 34'sh80000000;
            r_hn[0] <= 1'b1;
        end else if (w_a0 < -34'sh40000000) begin
            r_ha[0] <= w_a0 + 34'sh80000000;
            r_hn[0] <= 1'b1;
        end else begin
            r_ha[0] <= w_a0;
            r_hn[0] <= 1'b0;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_rot
        always_ff @(posedge i_clk) begin
            r_hn[g+1] <= r_hn[g];
            if (r_ha[g] >= 0) begin
                r_hx[g+1] <= r_hx[g] - (r_hy[g] >>> g);
                r_hy[g+1] <= r_hy[g] + (r_hx[g] >>> g);
                r_ha[g+1] <= r_ha[g] - 34'(lprpt_pkg::atan_entry(g));
            end else begin
                r_hx[g+1] <= r_hx[g] + (r_hy[g] >>> g);
                r_hy[g+1] <= r_hy[g] - (r_hx[g] >>> g);
                r_ha[g+1] <= r_ha[g] + 34'(lprpt_pkg::atan_entry(g));
            end
        end
    end

    logic signed [31:0] r_cos, r_sin;
    always_ff @(posedge i_clk) begin
        r_cos <= r_hn[N] ? 32'(-r_hx[N]) : 32'(r_hx[N]);
        r_sin <= r_hn[N] ? 32'(-r_hy[N]) : 32'(r_hy[N]);
    end

    // ---------------- stage 0: accept and filter ---------------------------
    logic w_take, w_keep;
    assign w_take = start && !busy;
    assign w_keep = i_point_finite &&
                    !(i_point_x < 19'sd200 && i_point_y < 19'sd200);

    logic               r_v0;
    logic signed [18:0] r_x0, r_y0, r_z0;
    logic        [7:0]  r_i0;
    logic        [63:0] r_n0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= w_take && w_keep;
        end
        r_x0 <= i_point_x;
        r_y0 <= i_point_y;
        r_z0 <= i_point_z;
        r_i0 <= i_intensity_in;
    end

    // squares, registered before the sum
    logic [36:0] r_sqx, r_sqy;
    always_ff @(posedge i_clk) begin
        r_sqx <= 37'(r_x0 * r_x0);
        r_sqy <= 37'(r_y0 * r_y0);
    end
    assign r_n0 = 64'({r_sqx + r_sqy, 16'h0});

    // ---------------- side channel delay for x, y, z, intensity ------------
    localparam int SD = LAT - 1;
    logic signed [18:0] r_dx [0:SD];
    logic signed [18:0] r_dy [0:SD];
    logic signed [18:0] r_dz [0:SD];
    logic        [7:0]  r_di [0:SD];
    logic               r_dv [0:SD];

    always_ff @(posedge i_clk) begin
        r_dx[0] <= r_x0;
        r_dy[0] <= r_y0;
        r_dz[0] <= r_z0;
        r_di[0] <= r_i0;
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else begin
            r_dv[0] <= r_v0;
        end
    end

    for (genvar g = 0; g < SD; g++) begin : g_dly
        always_ff @(posedge i_clk) begin
            r_dx[g+1] <= r_dx[g];
            r_dy[g+1] <= r_dy[g];
            r_dz[g+1] <= r_dz[g];
            r_di[g+1] <= r_di[g];
            if (!i_rst_n) begin
                r_dv[g+1] <= 1'b0;
            end else begin
                r_dv[g+1] <= r_dv[g];
            end
        end
    end

    // ---------------- square root: 4 bits per stage ------------------------
    // the first stage reads the squares register, aligned with r_dx[0]
    logic [63:0] r_sn [0:SQS];
    logic [63:0] r_sr [0:SQS];

    always_comb begin
        r_sn[0] = r_n0;
        r_sr[0] = '0;
    end

    for (genvar g = 0; g < SQS; g++) begin : g_sqrt
        logic [63:0] w_n, w_r;
        always_comb begin
            w_n = r_sn[g];
            w_r = r_sr[g];
            for (int k = 0; k < lprpt_pkg::SqrtSteps; k++) begin
                if (w_n >= w_r + (64'd1 << (62 - 2*(g*lprpt_pkg::SqrtSteps + k)))) begin
                    w_n = w_n - (w_r + (64'd1 << (62 - 2*(g*lprpt_pkg::SqrtSteps + k))));
                    w_r = (w_r >> 1) + (64'd1 << (62 - 2*(g*lprpt_pkg::SqrtSteps + k)));
                end else begin
                    w_r = w_r >> 1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            r_sn[g+1] <= w_n;
            r_sr[g+1] <= w_r;
        end
    end

    // vector input: (r, 256*z), z aligned with the sqrt output
    logic        w_ev_v;
    logic [31:0] w_elev_ang;
    lprpt_cordic_vec u_elev (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_dv[SQS]),
        .i_x     (44'(signed'({1'b0, r_sr[SQS][33:0]}))),
        .i_y     (44'(signed'({r_dz[SQS], 8'h0}))),
        .o_valid (w_ev_v),
        .o_angle (w_elev_ang)
    );

    // azimuth vectoring runs on the same delay line so results line up
    logic        w_az_v;
    logic [31:0] w_az_ang;
    lprpt_cordic_vec u_azim (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_dv[SQS]),
        .i_x     (44'(r_dx[SQS])),
        .i_y     (44'(r_dy[SQS])),
        .o_valid (w_az_v),
        .o_angle (w_az_ang)
    );

    // point at cordic output: index SQS + N + 1
    localparam int PC = SQS + N + 1;

    // ring from elevation: |elev| * 720 >> 32
    logic signed [31:0] w_elev;
    logic        [31:0] w_mag;
    logic        [41:0] w_prod;
    logic        [9:0]  w_dm;
    logic signed [7:0]  w_ring;
    logic        [3:0]  w_ring_c;
    logic        [31:0] w_az_h;
    logic        [15:0] w_az_r;

    always_comb begin
        w_elev = signed'(w_elev_ang);
        w_mag  = w_elev[31] ? 32'(-w_elev) : 32'(w_elev);
        w_prod = 42'(w_mag) * 42'd720;
        w_dm   = w_prod[41:32];
        if (w_dm == 10'd0) begin
            w_ring = 8'(lprpt_pkg::RingCount / 2 - 1);
        end else if (!w_elev[31]) begin
            w_ring = 8'(lprpt_pkg::RingCount / 2) + 8'(w_dm[9:2]);
        end else begin
            w_ring = 8'(lprpt_pkg::RingCount / 2 - 1) - 8'(w_dm[9:2]);
        end
        if (w_ring < 0) begin
            w_ring_c = 4'd0;
        end else if (w_ring > 8'sd15) begin
            w_ring_c = 4'd15;
        end else begin
            w_ring_c = w_ring[3:0];
        end
        w_az_h = w_az_ang + 32'h80000000;
        w_az_r = w_az_h[31:16] + 16'(w_az_h[15]);
    end

    // products of the rotation
    logic signed [50:0] r_pxc, r_pys, r_pxs, r_pyc;
    logic        [3:0]  r_ring1;
    logic        [15:0] r_az1;
    logic               r_v1;
    always_ff @(posedge i_clk) begin
        r_pxc   <= 51'(r_dx[PC] * r_cos);
        r_pys   <= 51'(r_dy[PC] * r_sin);
        r_pxs   <= 51'(r_dx[PC] * r_sin);
        r_pyc   <= 51'(r_dy[PC] * r_cos);
        r_ring1 <= w_ring_c;
        r_az1   <= w_az_r;
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= w_ev_v && w_az_v;
        end
    end

    // rounding and saturation of the rotated point
    logic signed [51:0] w_sx, w_sy;
    logic signed [21:0] w_tx, w_ty;
    logic signed [19:0] w_rx, w_ry;
    logic signed [25:0] w_wx, w_wy, w_wz;

    function automatic logic signed [19:0] sat20(input logic signed [21:0] v);
        logic signed [19:0] s;
        if (v > 22'sd524287) begin
            s = 20'sd524287;
        end else if (v < -22'sd524288) begin
            s = -20'sd524288;
        end else begin
            s = v[19:0];
        end
        return s;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
        logic signed [23:0] s;
        if (v > 26'sd8388607) begin
            s = 24'sd8388607;
        end else if (v < -26'sd8388608) begin
            s = -24'sd8388608;
        end else begin
            s = v[23:0];
        end
        return s;
    endfunction

    always_comb begin
        w_sx = 52'(r_pxc) - 52'(r_pys) + 52'sd536870912;
        w_sy = 52'(r_pxs) + 52'(r_pyc) + 52'sd536870912;
        w_tx = 22'(w_sx >>> 30);
        w_ty = 22'(w_sy >>> 30);
        w_rx = sat20(w_tx);
        w_ry = sat20(w_ty);
        w_wx = 26'(w_rx) + 26'(r_cfg.pose_x);
        w_wy = 26'(w_ry) + 26'(r_cfg.pose_y);
        w_wz = 26'(r_dz[PC + 1]) + 26'(r_cfg.sensor_height) + 26'(r_cfg.pose_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v1;
        end
        o_ring_id       <= r_ring1;
        o_azimuth       <= r_az1;
        o_rotated_x     <= w_rx;
        o_rotated_y     <= w_ry;
        o_rotated_z     <= r_dz[PC + 1];
        o_world_x       <= sat24(w_wx);
        o_world_y       <= sat24(w_wy);
        o_world_z       <= sat24(w_wz);
        o_intensity_out <= r_di[PC + 1];
    end

`ifndef ASSERT_OFF
    // both cordic pipelines see the same beat, so they stay in step
    a_cordic_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ev_v == w_az_v) else $error("cordic pipelines out of step");

    // the delay line valid matches the cordic output
    a_side_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ev_v == r_dv[PC]) else $error("side channel misaligned");

    // a non-finite point is dropped at the accept stage
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !i_point_finite) |=> !r_v0) else $error("non-finite point kept");

    // the block never stalls
    a_nobusy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy) else $error("busy raised");
`endif

endmodule

// File: src/lprpt_cordic_vec.sv
// ---------------------------------------------------------------------------
// lprpt_cordic_vec
// pipelined cordic vectoring: angle of (x, y) as a 32-bit binary angle
// ---------------------------------------------------------------------------
module lprpt_cordic_vec (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [43:0] i_x,
    input  logic signed [43:0] i_y,
    output logic               o_valid,
    output logic        [31:0] o_angle
);

    localparam int N = lprpt_pkg::CordicStages;

    logic signed [45:0] r_x   [0:N];
    logic signed [45:0] r_y   [0:N];
    logic        [31:0] r_ang [0:N];
    logic               r_v   [0:N];

    // pre-rotation into the right half plane
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        if (i_x < 0) begin
            r_x[0]   <= -46'(i_x);
            r_y[0]   <= -46'(i_y);
            r_ang[0] <= 32'h80000000;
        end else begin
            r_x[0]   <= 46'(i_x);
            r_y[0]   <= 46'(i_y);
            r_ang[0] <= 32'h0;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else begin
                r_v[g+1] <= r_v[g];
            end
            if (r_y[g] > 0) begin
                r_x[g+1]   <= r_x[g] + (r_y[g] >>> g);
                r_y[g+1]   <= r_y[g] - (r_x[g] >>> g);
                r_ang[g+1] <= r_ang[g] + lprpt_pkg::atan_entry(g);
            end else begin
                r_x[g+1]   <= r_x[g] - (r_y[g] >>> g);
                r_y[g+1]   <= r_y[g] + (r_x[g] >>> g);
                r_ang[g+1] <= r_ang[g] - lprpt_pkg::atan_entry(g);
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_angle = r_ang[N];

endmodule

// File: tb/point_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// point_checker
// watches the point, config and result channels of the lidar ring/pose
// block, predicts every result from its own copy of the registers and
// compares each result beat field by field against the oldest prediction
// ---------------------------------------------------------------------------
module point_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [18:0] i_point_x,
    input  logic signed [18:0] i_point_y,
    input  logic signed [18:0] i_point_z,
    input  logic        [7:0]  i_intensity_in,
    input  logic               i_point_finite,
    input  logic               i_cfg_we,
    input  logic        [2:0]  i_cfg_index,
    input  logic        [23:0] i_cfg_data,
    input  logic               o_valid,
    input  logic        [3:0]  o_ring_id,
    input  logic        [15:0] o_azimuth,
    input  logic signed [19:0] o_rotated_x,
    input  logic signed [19:0] o_rotated_y,
    input  logic signed [18:0] o_rotated_z,
    input  logic signed [23:0] o_world_x,
    input  logic signed [23:0] o_world_y,
    input  logic signed [23:0] o_world_z,
    input  logic        [7:0]  o_intensity_out,
    output int                 o_fail_count = 0,
    output int                 o_pending,
    output int                 o_point_count = 0,
    output int                 o_result_count = 0
);

    typedef struct packed {
        logic        [3:0]  ring_id;
        logic        [15:0] azimuth;
        logic signed [19:0] rot_x;
        logic signed [19:0] rot_y;
        logic signed [18:0] rot_z;
        logic signed [23:0] world_x;
        logic signed [23:0] world_y;
        logic signed [23:0] world_z;
        logic        [7:0]  intensity;
    } t_point_out;

    localparam logic [31:0] ArctanTab [0:15] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    t_point_out       expected_points[$];
    lprpt_pkg::t_cfg  cfg_copy;

    function automatic longint clamp_to(input longint v, input int w);
        longint hi, lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint root_floor(input longint unsigned n);
        longint unsigned res, bitv;
        res  = 0;
        bitv = longint'(1) << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    // vectoring: binary angle of (vx, vy)
    function automatic logic [31:0] vector_angle(input longint vx, input longint vy);
        logic [31:0] ang;
        longint dx, dy;
        ang = 32'h0;
        if (vx < 0) begin
            vx  = -vx;
            vy  = -vy;
            ang = 32'h80000000;
        end
        for (int i = 0; i < lprpt_pkg::CordicStages && i < 16; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy > 0) begin
                vx += dx; vy -= dy; ang += ArctanTab[i];
            end else begin
                vx -= dx; vy += dy; ang -= ArctanTab[i];
            end
        end
        return ang;
    endfunction

    // rotation mode: cos/sin of heading in q30
    task automatic heading_cos_sin(input logic [15:0] hd, output longint c, output longint s);
        longint ang, cx, sy, dx, dy;
        logic   flip;
        ang  = longint'($signed({hd, 16'h0}));
        cx   = lprpt_pkg::CordicGainQ30;
        sy   = 0;
        flip = 1'b0;
        if (ang > 64'sh40000000) begin
            ang -= 64'sh80000000; flip = 1'b1;
        end else if (ang < -64'sh40000000) begin
            ang += 64'sh80000000; flip = 1'b1;
        end
        for (int i = 0; i < lprpt_pkg::CordicStages && i < 16; i++) begin
            dx = sy >>> i;
            dy = cx >>> i;
            if (ang >= 0) begin
                cx -= dx; sy += dy; ang -= longint'(ArctanTab[i]);
            end else begin
                cx += dx; sy -= dy; ang += longint'(ArctanTab[i]);
            end
        end
        c = flip ? -cx : cx;
        s = flip ? -sy : sy;
    endtask

    task automatic predict_point(output bit keep, output t_point_out p);
        longint px, py, pz, r, elev, mag, d, ring, c, s, rx, ry;
        logic [31:0] az;
        px   = i_point_x;
        py   = i_point_y;
        pz   = i_point_z;
        p    = '0;
        keep = i_point_finite &&
               !(px < lprpt_pkg::MinXyMm && py < lprpt_pkg::MinXyMm);
        if (!keep) return;
        r    = root_floor(longint'(px * px + py * py) << 16);
        elev = longint'($signed(vector_angle(r, pz * 256)));
        mag  = elev < 0 ? -elev : elev;
        mag  = (mag * 720) >>> 32;
        d    = elev < 0 ? -mag : mag;
        if (d > 0) ring = lprpt_pkg::RingCount / 2 + d / 4;
        else       ring = lprpt_pkg::RingCount / 2 - 1 - (-d) / 4;
        if (ring < 0) ring = 0;
        if (ring > lprpt_pkg::RingCount - 1) ring = lprpt_pkg::RingCount - 1;
        az = vector_angle(px, py) + 32'h80000000;
        az = ((az >> 16) + ((az >> 15) & 32'h1)) & 32'hFFFF;
        heading_cos_sin(cfg_copy.heading, c, s);
        rx = clamp_to((px * c - py * s + (longint'(1) <<< 29)) >>> 30, 20);
        ry = clamp_to((px * s + py * c + (longint'(1) <<< 29)) >>> 30, 20);
        p.ring_id   = ring[3:0];
        p.azimuth   = az[15:0];
        p.rot_x     = rx[19:0];
        p.rot_y     = ry[19:0];
        p.rot_z     = i_point_z;
        p.world_x   = 24'(clamp_to(rx + cfg_copy.pose_x, 24));
        p.world_y   = 24'(clamp_to(ry + cfg_copy.pose_y, 24));
        p.world_z   = 24'(clamp_to(pz + cfg_copy.sensor_height + cfg_copy.pose_z, 24));
        p.intensity = i_intensity_in;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    assign o_pending = expected_points.size();

    always @(posedge i_clk) begin
        bit         keep;
        t_point_out p, w;
        if (!i_rst_n) begin
            cfg_copy <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lprpt_pkg::RegPoseX:    cfg_copy.pose_x        <= i_cfg_data;
                    lprpt_pkg::RegPoseY:    cfg_copy.pose_y        <= i_cfg_data;
                    lprpt_pkg::RegPoseZ:    cfg_copy.pose_z        <= i_cfg_data;
                    lprpt_pkg::RegHeading:  cfg_copy.heading       <= i_cfg_data[15:0];
                    lprpt_pkg::RegSensorHt: cfg_copy.sensor_height <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (o_valid) begin
                o_result_count++;
                if (expected_points.size() == 0) begin
                    report_mismatch("unexpected result beat", 1, 0);
                end else begin
                    w = expected_points.pop_front();
                    if (o_ring_id != w.ring_id)
                        report_mismatch("ring_id", o_ring_id, w.ring_id);
                    if (o_azimuth != w.azimuth)
                        report_mismatch("azimuth", o_azimuth, w.azimuth);
                    if (o_rotated_x != w.rot_x)
                        report_mismatch("rotated_x", o_rotated_x, w.rot_x);
                    if (o_rotated_y != w.rot_y)
                        report_mismatch("rotated_y", o_rotated_y, w.rot_y);
                    if (o_rotated_z != w.rot_z)
                        report_mismatch("rotated_z", o_rotated_z, w.rot_z);
                    if (o_world_x != w.world_x)
                        report_mismatch("world_x", o_world_x, w.world_x);
                    if (o_world_y != w.world_y)
                        report_mismatch("world_y", o_world_y, w.world_y);
                    if (o_world_z != w.world_z)
                        report_mismatch("world_z", o_world_z, w.world_z);
                    if (o_intensity_out != w.intensity)
                        report_mismatch("intensity_out", o_intensity_out, w.intensity);
                end
            end
            if (start && !busy) begin
                o_point_count++;
                predict_point(keep, p);
                if (keep) expected_points.push_back(p);
            end
        end
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// drives lidar points and register settings into the ring/pose block; the
// checker beside it predicts and compares every result beat
// ---------------------------------------------------------------------------
module testbench;

    localparam int Latency = 32 + 2 * lprpt_pkg::CordicStages + 16;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [18:0] i_point_x, i_point_y, i_point_z;
    logic        [7:0]  i_intensity_in;
    logic               i_point_finite;
    logic               i_cfg_we;
    logic        [2:0]  i_cfg_index;
    logic        [23:0] i_cfg_data;
    logic               o_valid;
    logic        [3:0]  o_ring_id;
    logic        [15:0] o_azimuth;
    logic signed [19:0] o_rotated_x, o_rotated_y;
    logic signed [18:0] o_rotated_z;
    logic signed [23:0] o_world_x, o_world_y, o_world_z;
    logic        [7:0]  o_intensity_out;
    int                 fail_count, pending, point_count, result_count;
    bit                 steady_stream;

    lidar_point_ring_and_pose_transform uut (.*);

    point_checker u_checker (
        .*,
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_point_count  (point_count),
        .o_result_count (result_count)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    initial begin
        #20ms;
        $display("testbench: errors");
        $finish;
    end

    task automatic send_point(input int px, input int py, input int pz,
                              input int inten, input bit fin);
        while (!steady_stream && $urandom_range(99) < 7) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        i_point_x      <= 19'(px);
        i_point_y      <= 19'(py);
        i_point_z      <= 19'(pz);
        i_intensity_in <= 8'(inten);
        i_point_finite <= fin;
        start          <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    // drain, then write all registers and let the heading pipeline settle
    task automatic set_pose(input int x, input int y, input int z,
                            input int hd, input int ht);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (Latency) @(posedge i_clk);
        write_reg(lprpt_pkg::RegPoseX, 24'(x));
        write_reg(lprpt_pkg::RegPoseY, 24'(y));
        write_reg(lprpt_pkg::RegPoseZ, 24'(z));
        write_reg(lprpt_pkg::RegHeading, 24'(hd));
        write_reg(lprpt_pkg::RegSensorHt, 24'(ht));
        i_cfg_we <= 1'b0;
        repeat (Latency) @(posedge i_clk);
    endtask

    task automatic random_points(input int n);
        int px, py, pz, sel;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(99);
            if (sel < 60) begin
                px = $signed(19'($urandom));
                py = $signed(19'($urandom));
                pz = $signed(19'($urandom));
            end else begin
                px = $urandom_range(4000) - 2000;
                py = $urandom_range(4000) - 2000;
                pz = $urandom_range(2000) - 1000;
            end
            // keep most points past the distance filter
            if (sel < 85 && px < lprpt_pkg::MinXyMm && py < lprpt_pkg::MinXyMm)
                px = lprpt_pkg::MinXyMm + $urandom_range(50000);
            steady_stream = (k >= n / 3 && k < n / 3 + 120);
            send_point(px, py, pz, $urandom_range(255), $urandom_range(99) < 92);
        end
        steady_stream = 1'b0;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_point_x      = '0;
        i_point_y      = '0;
        i_point_z      = '0;
        i_intensity_in = '0;
        i_point_finite = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        steady_stream  = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: filter cases, field extremes, ring saturation, azimuth quadrants
        send_point(5000, 5000, 100, 0, 1'b0);
        send_point(199, 199, 0, 17, 1'b1);
        send_point(199, 200, 0, 18, 1'b1);
        send_point(200, -262144, 0, 255, 1'b1);
        send_point(262143, 262143, 262143, 255, 1'b1);
        send_point(-262144, 262143, -262144, 0, 1'b1);
        send_point(262143, -262144, -262144, 128, 1'b1);
        send_point(300, 0, 262143, 1, 1'b1);
        send_point(0, 300, -262144, 2, 1'b1);
        send_point(-262144, 300, 0, 3, 1'b1);
        send_point(-5000, 250, -1, 4, 1'b1);
        send_point(10000, 0, 0, 5, 1'b1);
        send_point(-200, 1000, 50, 6, 1'b1);
        set_pose(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'h4000, 16'h7FFF);
        write_reg(3'd7, 24'hFFFFFF);
        write_reg(3'd5, 24'h123456);
        i_cfg_we <= 1'b0;
        send_point(262143, 262143, 262143, 9, 1'b1);
        send_point(-262144, 262143, 262143, 10, 1'b1);
        send_point(262143, -262144, -262144, 11, 1'b1);
        send_point(1000, 1000, 0, 12, 1'b1);
        set_pose(24'h800000, 24'h7FFFFF, 24'h800000, 16'hFFFF, 16'h8000);
        send_point(-262144, -100, -262144, 13, 1'b1);
        send_point(262143, 262143, -262144, 14, 1'b1);
        send_point(1000, -1000, 0, 15, 1'b1);

        set_pose(0, 0, 0, 16'h8000, 0);
        random_points(140);
        set_pose(123456, -654321, 1500, 16'hC000, 1800);
        random_points(140);
        set_pose(24'h7FFFF0, 24'h80000F, -3000000, 16'h0001, -32768);
        random_points(140);
        set_pose($urandom, $urandom, $urandom, $urandom, $urandom);
        random_points(140);
        set_pose($urandom, $urandom, $urandom, 16'h4000, 32767);
        random_points(140);
        set_pose(0, 0, 0, 16'hFFFF, 0);
        random_points(130);

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (Latency) @(posedge i_clk);
        $display("covered %0d points, %0d result beats, over eight pose/heading settings",
                 point_count, result_count);
        $display("including saturated pose, extreme coordinates and filtered points");
        if (fail_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
